// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the range add/assign sum tree controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ratst_pkg.sv =====
// Types and constants shared by the range add/assign sum tree modules.
package ratst_pkg;

  localparam int SUM_W = 64;
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ASSIGN = 2'd1,
    KIND_ADD    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_ENTER = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } phase_t;

  // where the tag sequence goes when its write is done
  typedef enum logic [1:0] {
    RET_POP = 2'd0,
    RET_PR  = 2'd1,
    RET_CLR = 2'd2
  } tret_t;

  typedef struct packed {
    kind_t             kind;
    logic [SUM_W-1:0]  val;
    logic [SUM_W-1:0]  sum;
  } node_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd_en;
    logic tag_ld;
    logic tag_par;
    logic user_add;
    logic tag_wr;
    logic par_cap;
    logic par_clr_wr;
    logic lsum_cap;
    logic sum_wr;
    logic acc_add;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_none;
  } dp_sts_t;

endpackage

// ===== rtl/core/ratst_dp.sv =====
// Datapath: node memory, tag multiply, tag merge and sum accumulator.
module ratst_dp import ratst_pkg::*; #(
  parameter int AW    = 12,
  parameter int LW    = 11,
  parameter int SLOTS = 4096
) (
  input  logic                    clk,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [AW-1:0]           addr,
  input  logic [LW-1:0]           len,
  input  logic signed [VAL_W-1:0] value,
  output logic signed [SUM_W-1:0] range_sum
);

  node_t            mem [SLOTS];
  node_t            rd;
  node_t            wdata;
  node_t            tag_out;
  logic [SUM_W-1:0] uval;
  kind_t            tkind;
  logic [SUM_W-1:0] tval;
  kind_t            pkind;
  logic [SUM_W-1:0] pval;
  logic [SUM_W-1:0] psum;
  logic [SUM_W-1:0] lsum;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] prod;
  logic [31+LW:0]   pl;
  logic [31+LW:0]   ph;
  logic [SUM_W-1:0] tv_sel;
  logic             we;

  assign we = cmd.clear_wr | cmd.tag_wr | cmd.par_clr_wr | cmd.sum_wr;
  assign tv_sel = cmd.tag_par ? pval : uval;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd <= mem[addr];
    end
  end

  // len * v split into two 32-bit halves, recombined the next cycle
  always_ff @(posedge clk) begin
    pl   <= (32+LW)'(tv_sel[31:0]) * (32+LW)'(len);
    ph   <= (32+LW)'(tv_sel[63:32]) * (32+LW)'(len);
    prod <= SUM_W'(pl) + {ph[31:0], 32'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      uval <= SUM_W'(value);
      acc  <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + rd.sum;
    end
    if (cmd.tag_ld) begin
      if (cmd.tag_par) begin
        tkind <= pkind;
      end else begin
        tkind <= cmd.user_add ? KIND_ADD : KIND_ASSIGN;
      end
      tval <= tv_sel;
    end
    if (cmd.par_cap) begin
      pkind <= rd.kind;
      pval  <= rd.val;
      psum  <= rd.sum;
    end
    if (cmd.lsum_cap) begin
      lsum <= rd.sum;
    end
  end

  always_comb begin
    if (tkind == KIND_ASSIGN) begin
      tag_out.kind = KIND_ASSIGN;
      tag_out.val  = tval;
      tag_out.sum  = prod;
    end else begin
      tag_out.kind = (rd.kind == KIND_NONE) ? KIND_ADD : rd.kind;
      tag_out.val  = (rd.kind == KIND_NONE) ? tval : rd.val + tval;
      tag_out.sum  = rd.sum + prod;
    end
  end

  always_comb begin
    wdata = '0;
    if (cmd.tag_wr) begin
      wdata = tag_out;
    end else if (cmd.par_clr_wr) begin
      wdata.kind = KIND_NONE;
      wdata.sum  = psum;
    end else if (cmd.sum_wr) begin
      wdata.kind = KIND_NONE;
      wdata.sum  = lsum + rd.sum;
    end
  end

  assign sts.rd_none = (rd.kind == KIND_NONE);
  assign range_sum   = acc;

endmodule

// ===== rtl/core/ratst_ctrl.sv =====
// Controller: clearing pass, traversal stack and tree-walk sequencer.
`include "assert_macros.svh"

module ratst_ctrl import ratst_pkg::*; #(
  parameter int NUM_ELEMENTS = 1024,
  parameter int IW           = 10,
  parameter int LW           = 11,
  parameter int AW           = 12,
  parameter int SLOTS        = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op,
  input  logic [IDX_W-1:0] lo_index,
  input  logic [IDX_W-1:0] hi_index,
  output dp_cmd_t          dp_cmd,
  input  dp_sts_t          dp_sts,
  output logic [AW-1:0]    addr,
  output logic [LW-1:0]    len,
  output logic             result_valid
);

  localparam int DEPTH = IW + 1;
  localparam int SPW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (IW > IDX_W) ? IW : IDX_W;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CLEAR   = 16'h0002,
    S_ENTER   = 16'h0004,
    S_TAG_RD  = 16'h0008,
    S_TAG_MUL = 16'h0010,
    S_TAG_WR  = 16'h0020,
    S_Q_RD    = 16'h0040,
    S_Q_ACC   = 16'h0080,
    S_PAR_RD  = 16'h0100,
    S_PAR_CHK = 16'h0200,
    S_PAR_CLR = 16'h0400,
    S_SUM_L   = 16'h0800,
    S_SUM_R   = 16'h1000,
    S_SUM_W   = 16'h2000,
    S_POP     = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   stk_node [DEPTH];
  logic [IW-1:0]   stk_s    [DEPTH];
  logic [IW-1:0]   stk_e    [DEPTH];
  phase_t          stk_ph   [DEPTH];
  logic [SPW-1:0]  sp;
  logic [AW-1:0]   clr_cnt;
  logic [IW-1:0]   lo_r, hi_r;
  logic            is_query, is_add;
  tret_t           tret;

  logic [AW-1:0]   cur_node, l_node, r_node;
  logic [IW-1:0]   cur_s, cur_e, cur_m;
  phase_t          cur_ph;
  logic [LW-1:0]   m_full;
  logic            covered, outside;
  logic [XW-1:0]   lo_x, hi_x, hi_c;
  logic            live, accept, descend;

  assign cur_node = stk_node[sp];
  assign cur_s    = stk_s[sp];
  assign cur_e    = stk_e[sp];
  assign cur_ph   = stk_ph[sp];
  assign m_full   = (LW'(cur_s) + LW'(cur_e)) >> 1;
  assign cur_m    = m_full[IW-1:0];
  assign l_node   = {cur_node[AW-2:0], 1'b0};
  assign r_node   = {cur_node[AW-2:0], 1'b1};
  assign covered  = (lo_r <= cur_s) && (cur_e <= hi_r);
  assign outside  = (cur_s > hi_r) || (lo_r > cur_e);

  // clip hi to the array, then check for an empty range
  assign lo_x   = XW'(lo_index);
  assign hi_x   = XW'(hi_index);
  assign hi_c   = (hi_x > XW'(NUM_ELEMENTS - 1)) ? XW'(NUM_ELEMENTS - 1) : hi_x;
  assign live   = (lo_x <= hi_c);
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign descend = ((state == S_PAR_CHK) && dp_sts.rd_none) || (state == S_PAR_CLR);
  assign result_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_ADD, OP_ASSIGN: state_next = live ? S_ENTER : S_IDLE;
            OP_QUERY:          state_next = live ? S_ENTER : S_DONE;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR:   state_next = (clr_cnt == AW'(SLOTS - 1)) ? S_IDLE : S_CLEAR;
      S_ENTER: begin
        case (cur_ph)
          PH_ENTER: begin
            if (outside) begin
              state_next = S_POP;
            end else if (covered) begin
              state_next = is_query ? S_Q_RD : S_TAG_RD;
            end else begin
              state_next = S_PAR_RD;
            end
          end
          PH_LEFT:  state_next = S_ENTER;
          default:  state_next = is_query ? S_POP : S_SUM_L;
        endcase
      end
      S_TAG_RD:  state_next = S_TAG_MUL;
      S_TAG_MUL: state_next = S_TAG_WR;
      S_TAG_WR: begin
        case (tret)
          RET_PR:  state_next = S_TAG_RD;
          RET_CLR: state_next = S_PAR_CLR;
          default: state_next = S_POP;
        endcase
      end
      S_Q_RD:    state_next = S_Q_ACC;
      S_Q_ACC:   state_next = S_POP;
      S_PAR_RD:  state_next = S_PAR_CHK;
      S_PAR_CHK: state_next = dp_sts.rd_none ? S_ENTER : S_TAG_RD;
      S_PAR_CLR: state_next = S_ENTER;
      S_SUM_L:   state_next = S_SUM_R;
      S_SUM_R:   state_next = S_SUM_W;
      S_SUM_W:   state_next = S_POP;
      S_POP: begin
        if (sp == '0) begin
          state_next = is_query ? S_DONE : S_IDLE;
        end else begin
          state_next = S_ENTER;
        end
      end
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      sp      <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if ((state == S_IDLE) && accept) begin
        sp          <= '0;
        stk_node[0] <= AW'(1);
        stk_s[0]    <= '0;
        stk_e[0]    <= IW'(NUM_ELEMENTS - 1);
        stk_ph[0]   <= PH_ENTER;
        lo_r        <= lo_x[IW-1:0];
        hi_r        <= hi_c[IW-1:0];
        is_query    <= (op == OP_QUERY);
        is_add      <= (op == OP_ADD);
      end
      if ((state == S_ENTER) && (cur_ph == PH_ENTER) && !outside && covered) begin
        tret <= RET_POP;
      end
      if ((state == S_PAR_CHK) && !dp_sts.rd_none) begin
        tret <= RET_PR;
      end
      if ((state == S_TAG_WR) && (tret == RET_PR)) begin
        tret <= RET_CLR;
      end
      if (descend) begin
        stk_ph[sp]             <= PH_LEFT;
        stk_node[sp + SPW'(1)] <= l_node;
        stk_s[sp + SPW'(1)]    <= cur_s;
        stk_e[sp + SPW'(1)]    <= cur_m;
        stk_ph[sp + SPW'(1)]   <= PH_ENTER;
        sp                     <= sp + SPW'(1);
      end
      if ((state == S_ENTER) && (cur_ph == PH_LEFT)) begin
        stk_ph[sp]             <= PH_RIGHT;
        stk_node[sp + SPW'(1)] <= r_node;
        stk_s[sp + SPW'(1)]    <= cur_m + IW'(1);
        stk_e[sp + SPW'(1)]    <= cur_e;
        stk_ph[sp + SPW'(1)]   <= PH_ENTER;
        sp                     <= sp + SPW'(1);
      end
      if ((state == S_POP) && (sp != '0)) begin
        sp <= sp - SPW'(1);
      end
    end
  end

  // address and length for the datapath
  always_comb begin
    addr = cur_node;
    case (state)
      S_CLEAR: addr = clr_cnt;
      S_TAG_RD, S_TAG_MUL, S_TAG_WR: begin
        case (tret)
          RET_PR:  addr = l_node;
          RET_CLR: addr = r_node;
          default: addr = cur_node;
        endcase
      end
      S_SUM_L: addr = l_node;
      S_SUM_R: addr = r_node;
      default: addr = cur_node;
    endcase
  end

  always_comb begin
    case (tret)
      RET_PR:  len = LW'(cur_m) - LW'(cur_s) + LW'(1);
      RET_CLR: len = LW'(cur_e) - LW'(cur_m);
      default: len = LW'(cur_e) - LW'(cur_s) + LW'(1);
    endcase
  end

  always_comb begin
    dp_cmd            = '0;
    dp_cmd.clear_wr   = (state == S_CLEAR);
    dp_cmd.load       = (state == S_IDLE) && accept;
    dp_cmd.rd_en      = (state == S_TAG_RD) || (state == S_Q_RD) || (state == S_PAR_RD) ||
                        (state == S_SUM_L) || (state == S_SUM_R);
    dp_cmd.tag_ld     = (state == S_TAG_RD);
    dp_cmd.tag_par    = (tret != RET_POP);
    dp_cmd.user_add   = is_add;
    dp_cmd.tag_wr     = (state == S_TAG_WR);
    dp_cmd.par_cap    = (state == S_PAR_CHK);
    dp_cmd.par_clr_wr = (state == S_PAR_CLR);
    dp_cmd.lsum_cap   = (state == S_SUM_R);
    dp_cmd.sum_wr     = (state == S_SUM_W);
    dp_cmd.acc_add    = (state == S_Q_ACC);
  end

  `ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held over two cycles")
  `ASSERT_ALWAYS(a_sp_bound, sp <= SPW'(DEPTH - 1), "traversal stack overflow")
  `ASSERT_ALWAYS(a_frame_order, (state == S_ENTER) |-> (cur_s <= cur_e), "empty frame on stack")
  `ASSERT_ALWAYS(a_idle_quiet,
                 (state == S_IDLE) |-> !(dp_cmd.tag_wr || dp_cmd.sum_wr || dp_cmd.par_clr_wr),
                 "tree write while idle")

endmodule

// ===== rtl/core/range_add_assign_sum_tree.sv =====
// Top level of the range add / range assign / range sum tree.
//
// Range add, range assign and range sum over NUM_ELEMENTS signed values kept
// in a lazy-tag segment tree. Issue a beat by raising start while busy is low;
// cmd selects add (OP_ADD), assign (OP_ASSIGN) or sum query (OP_QUERY) over the
// inclusive range lo_index..hi_index, and hi_index is clipped to the array.
// A query returns one beat on range_sum, marked by result_valid for exactly one
// cycle; the receiver cannot stall, so it must take the beat in that cycle.
// Add and assign return nothing. An empty range changes nothing and a query
// over it returns zero; cmd 3 is ignored. Sums wrap modulo 2^64.
// Every command runs on its own through one single-port node memory.
// A visited tree node is either skipped, fully covered (a query reads and
// accumulates its sum, add/assign rewrite its tag) or split (parent read,
// lazy push to both children through a read/multiply/write sequence, and
// for add/assign a child-sum write back). A command visits about
// 4*log2(NUM_ELEMENTS) nodes; busy never rises for an empty add or assign or
// for cmd 3, and a query adds a result beat after its walk. After reset the
// block runs a clearing pass over all 4*NUM_ELEMENTS node slots
// with busy high.
module range_add_assign_sum_tree import ratst_pkg::*; #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic [IDX_W-1:0]        lo_index,
  input  logic [IDX_W-1:0]        hi_index,
  input  logic signed [VAL_W-1:0] value,
  output logic                    result_valid,
  output logic signed [SUM_W-1:0] range_sum
);

  // node i covers a span; children 2i and 2i+1 stay below 4*N
  localparam int IW    = $clog2(NUM_ELEMENTS);
  localparam int LW    = IW + 1;
  localparam int SLOTS = 4 * NUM_ELEMENTS;
  localparam int AW    = $clog2(SLOTS);

  dp_cmd_t       dp_cmd;
  dp_sts_t       dp_sts;
  logic [AW-1:0] addr;
  logic [LW-1:0] len;

  // sequencer: walks the tree with an explicit frame stack
  ratst_ctrl #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .IW           (IW),
    .LW           (LW),
    .AW           (AW),
    .SLOTS        (SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (cmd),
    .lo_index     (lo_index),
    .hi_index     (hi_index),
    .dp_cmd       (dp_cmd),
    .dp_sts       (dp_sts),
    .addr         (addr),
    .len          (len),
    .result_valid (result_valid)
  );

  // node memory, tag arithmetic and the query accumulator
  ratst_dp #(
    .AW    (AW),
    .LW    (LW),
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .addr      (addr),
    .len       (len),
    .value     (value),
    .range_sum (range_sum)
  );

endmodule
